/* sv/bse_pkg.sv */
package bse_pkg;

    localparam int MAX_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 9;
    localparam int FILL_W    = 9;
    localparam int CAP_RESET = 256;
    // Width used to compare the capacity register against the fill count.
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DUP   = 3'd3,
        CMD_SWAP  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_SEC,
        S_WR2,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [STAT_W-1:0]        status;
        logic [FILL_W-1:0]        fill_count;
    } result_t;

endpackage

/* sv/bse_req_if.sv */
interface bse_req_if;
    import bse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink (input valid, input cmd, input push_value, output ready);
endinterface

/* sv/bse_rsp_if.sv */
interface bse_rsp_if;
    import bse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output data_out, output status, output fill_count,
                    input ready);
    modport sink (input valid, input data_out, input status, input fill_count,
                  output ready);
endinterface

/* sv/bse_ram.sv */
module bse_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* sv/bse_ctrl.sv */
module bse_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [bse_pkg::CMD_W-1:0] req_cmd,
    input  logic [bse_pkg::DATA_W-1:0] req_push_value,
    input  logic [bse_pkg::CAP_W-1:0] capacity,
    input  logic                      out_free,
    output logic                      res_valid,
    output bse_pkg::result_t          res,
    output bse_pkg::mem_req_t         mem_req,
    input  logic [bse_pkg::DATA_W-1:0] rd_data
);
    import bse_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] data_reg, data_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] top_reg, top_next;

    logic [CMP_W-1:0]  cap_lim;
    logic              full;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] sec_addr;
    logic [ADDR_W-1:0] push_addr;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;

    // The usable capacity is the register value clamped to the store depth.
    assign cap_lim = (CMP_W'(capacity) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
                                                             : CMP_W'(capacity);
    assign full      = CMP_W'(count_reg) >= cap_lim;
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_m2  = count_reg - CNT_W'(2);
    assign top_addr  = count_m1[ADDR_W-1:0];
    assign sec_addr  = count_m2[ADDR_W-1:0];
    assign push_addr = count_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        top_reg    <= top_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        data_next   = data_reg;
        status_next = status_reg;
        top_next    = top_reg;
        mem_req     = '0;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = cmd_t'(req_cmd);
                    data_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_OUT;
                    case (cmd_t'(req_cmd))
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = push_addr;
                                mem_req.wr_data = req_push_value;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = top_addr;
                                state_next      = S_TOP;
                                if (cmd_t'(req_cmd) == CMD_POP)
                                begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        CMD_DUP:
                        begin
                            // The empty test takes precedence over the full test.
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = top_addr;
                                state_next      = S_TOP;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                status_next = ST_FEW;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = top_addr;
                                state_next      = S_TOP;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TOP:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_POP, CMD_PEEK:
                    begin
                        data_next = rd_data;
                    end
                    CMD_DUP:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = push_addr;
                        mem_req.wr_data = rd_data;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    CMD_SWAP:
                    begin
                        top_next        = rd_data;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = sec_addr;
                        state_next      = S_SEC;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SEC:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = top_addr;
                mem_req.wr_data = rd_data;
                state_next      = S_WR2;
            end
            S_WR2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sec_addr;
                mem_req.wr_data = top_reg;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.data_out   = data_reg;
    assign res.status     = status_reg;
    assign res.fill_count = FILL_W'(count_reg);
endmodule

/* sv/bounded_stack_engine.sv */
// Push, clear, unused codes and refused requests go straight to the result state; pop,
// peek and duplicate first read the top entry; swap reads the top and second entries
// and writes both back. Requests are taken one at a time; the steps follow from the
// single read and single write port of the element RAM and its registered read port.
// Reset (rst_n, asynchronous, active low) empties the stack and sets capacity to 256;
// element RAM contents are not cleared and need no clearing pass.
module bounded_stack_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    bse_req_if.sink                  req,
    bse_rsp_if.source                rsp,
    input  logic                     cfg_we,
    input  logic [bse_pkg::CAP_W-1:0] cfg_wdata
);
    import bse_pkg::*;

    // Capacity register: the user writes it only while no request is in flight; not enforced by the block.
    logic [CAP_W-1:0] cap_reg;

    // Result register. It parts the controller from the response channel, so the
    // controller can take the next request while an earlier result waits here.
    logic             out_valid_reg;
    result_t          out_reg;

    logic              out_free;
    logic              res_valid;
    result_t           res;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // The result register is free when it is empty or is being drained this cycle.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = out_reg.data_out;
    assign rsp.status     = out_reg.status;
    assign rsp.fill_count = out_reg.fill_count;

    // The controller decodes each request, tracks the fill count and steps through the
    // read, modify and write-back cycles on the element RAM. Requests are handled one
    // at a time, so no two RAM accesses to the same entry ever overlap.
    bse_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_ready      (req.ready),
        .req_cmd        (req.cmd),
        .req_push_value (req.push_value),
        .capacity       (cap_reg),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res),
        .mem_req        (mem_req),
        .rd_data        (rd_data)
    );

    // Element store: one write port and one registered read port.
    bse_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // A request in flight blocks the next one until its result has moved on.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // A refused request never returns a data word.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.data_out == '0)
        else $error("refused request returned nonzero data");

    // The reported fill count never exceeds the store depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (FILL_W + 1)'(rsp.fill_count) <= (FILL_W + 1)'(MAX_DEPTH))
        else $error("fill count exceeds store depth");

    // A result held back by the sink stays valid.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.fill_count)))
        else $error("stalled result dropped or changed");
`endif
endmodule

/* dv/bse_stack_checker.sv */
module bse_stack_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    bse_req_if                        req,
    bse_rsp_if                        rsp,
    input  logic                      cfg_we,
    input  logic [bse_pkg::CAP_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        outstanding,
    output int                        results_checked,
    output int                        peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    logic signed [DATA_W-1:0] shadow_mem [MAX_DEPTH];
    int unsigned              fill;
    int unsigned              cap_reg;
    result_t                  pending_results [$];

    // Applies one request to the shadow stack and returns the result it must produce.
    function automatic result_t apply_stack_cmd(input logic [CMD_W-1:0]         code,
                                                input logic signed [DATA_W-1:0] word);
        result_t                  res;
        int unsigned              limit;
        logic signed [DATA_W-1:0] held;
        res   = '0;
        limit = (cap_reg > MAX_DEPTH) ? MAX_DEPTH : cap_reg;
        case (code)
            CMD_PUSH:
                if (fill >= limit)
                    res.status = ST_FULL;
                else
                begin
                    shadow_mem[fill] = word;
                    fill++;
                end
            CMD_POP:
                if (fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    fill--;
                    res.data_out = shadow_mem[fill];
                end
            CMD_PEEK:
                if (fill == 0)
                    res.status = ST_EMPTY;
                else
                    res.data_out = shadow_mem[fill-1];
            CMD_DUP:
                // The empty test takes precedence over the full test.
                if (fill == 0)
                    res.status = ST_EMPTY;
                else if (fill >= limit)
                    res.status = ST_FULL;
                else
                begin
                    shadow_mem[fill] = shadow_mem[fill-1];
                    fill++;
                end
            CMD_SWAP:
                if (fill < 2)
                    res.status = ST_FEW;
                else
                begin
                    held               = shadow_mem[fill-1];
                    shadow_mem[fill-1] = shadow_mem[fill-2];
                    shadow_mem[fill-2] = held;
                end
            CMD_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        res.fill_count = FILL_W'(fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fill            = 0;
            cap_reg         = CAP_RESET;
            fail_count      = 0;
            results_checked = 0;
            peak_fill       = 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (req.valid && req.ready)
            begin
                pending_results.push_back(apply_stack_cmd(req.cmd, req.push_value));
                if (fill > peak_fill)
                    peak_fill = fill;
            end
            if (rsp.valid && rsp.ready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected result: expected no result, ",
                              "got data=%0d status=%0d fill=%0d"},
                             $time, rsp.data_out, rsp.status, rsp.fill_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.data_out !== want.data_out || rsp.status !== want.status ||
                        rsp.fill_count !== want.fill_count)
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch: expected data=%0d status=%0d ",
                                  "fill=%0d, got data=%0d status=%0d fill=%0d"},
                                 $time, want.data_out, want.status, want.fill_count,
                                 rsp.data_out, rsp.status, rsp.fill_count);
                    end
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

/* dv/bounded_stack_engine_tb.sv */
module bounded_stack_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    // Command codes six and seven are unused by the block; they must act as no-ops.
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int               NUM_PHASES  = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CAP_W-1:0]   cfg_wdata;

    int                 fail_count;
    int                 outstanding;
    int                 results_checked;
    int                 peak_fill;

    // Bookkeeping for the closing summary.
    int                 requests_sent;
    int                 cap_writes;

    // When set, the matching side of the handshake runs without any idle cycles.
    bit                 send_quiet;
    bit                 recv_quiet;

    bse_req_if req_ch ();
    bse_rsp_if rsp_ch ();

    bounded_stack_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // The checker watches both channels and the capacity port, keeps its own copy of the
    // stack and compares every result; the top only drives stimulus.
    bse_stack_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .peak_fill       (peak_fill)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length for either side: mostly none, often a few cycles, now and then a long
    // stretch so that stalls land on every internal phase of a multi-cycle command.
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Push payloads lean on the sign boundaries and all-ones/all-zeros now and then.
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // push_bias is the percentage of requests that try to grow the stack. Clear can be
    // left out so that a fill phase is sure to reach the capacity.
    function automatic logic [CMD_W-1:0] pick_cmd(input int push_bias, input bit allow_clear);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_bias)
            return ($urandom_range(0, 3) == 0) ? CMD_DUP : CMD_PUSH;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return CMD_POP;
        else if (roll < 65)
            return CMD_PEEK;
        else if (roll < 88)
            return CMD_SWAP;
        else if (roll < 94)
            return allow_clear ? CMD_CLEAR : CMD_PEEK;
        else
            return ($urandom_range(0, 1) == 0) ? CMD_RSVD_LO : CMD_RSVD_HI;
    endfunction

    // Presents one request and returns right after the edge that accepts it. Valid is
    // left high so back-to-back requests need no bubble; the next call lowers it only
    // when it wants a gap.
    task automatic send_request(input logic [CMD_W-1:0] code,
                                input logic signed [DATA_W-1:0] word);
        int idle;
        idle = pick_gap(send_quiet);
        @(negedge clk);
        if (idle > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= code;
        req_ch.push_value <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
    endtask

    // Withdraws the request channel and holds off until every result has been returned.
    // The extra cycles cover the longest command latency of the block.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (6) @(posedge clk);
    endtask

    // The capacity register is written only while the block is idle.
    task automatic set_capacity(input int cap);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(cap);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // Directed requests: pop, peek, swap, duplicate and push on an empty stack, single-entry
    // swap, sign extremes through push, duplicate, swap and pop, the unused codes, clear, and
    // then the capacity corner cases (tiny capacity, capacity below the fill, capacity zero).
    task automatic run_directed();
        send_request(CMD_POP, '0);
        send_request(CMD_PEEK, '0);
        send_request(CMD_SWAP, '0);
        send_request(CMD_DUP, '0);
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_SWAP, '1);
        send_request(CMD_DUP, '0);
        send_request(CMD_PUSH, 32'sh8000_0000);
        send_request(CMD_PEEK, '0);
        send_request(CMD_SWAP, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_PUSH, '1);
        send_request(CMD_PUSH, 32'sh5555_AAAA);
        send_request(CMD_RSVD_LO, 32'sh1234_5678);
        send_request(CMD_RSVD_HI, '1);
        send_request(CMD_CLEAR, '1);
        send_request(CMD_POP, '0);

        // A capacity of one: the second push and a duplicate are refused as full.
        set_capacity(1);
        send_request(CMD_PUSH, 32'sh0BAD_F00D);
        send_request(CMD_PUSH, 32'sh0000_0001);
        send_request(CMD_DUP, '0);
        send_request(CMD_PEEK, '0);

        // Capacity zero with one entry held: growth is refused, reads still work.
        set_capacity(0);
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_DUP, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_DUP, '0);
        send_request(CMD_SWAP, '0);
    endtask

    // Background process that stalls the result channel.
    initial
    begin
        int stall;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall = pick_gap(recv_quiet);
            end
        end
    end

    // Hard stop in case the block hangs; far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int phase_cap   [NUM_PHASES];
        int phase_len   [NUM_PHASES];
        int phase_bias  [NUM_PHASES];
        int cap;

        // Random phases: small capacities, a long push-heavy run to the full 256
        // entries, a capacity above the depth, a capacity far below the current fill so
        // the stack drains while reported full, capacity zero, the register maximum and
        // a random setting. A negative entry means a random capacity.
        phase_cap  = '{4, 1, 256, 300, 3, 0, 511, -1};
        phase_len  = '{120, 80, 380, 100, 120, 60, 90, 100};
        phase_bias = '{45, 45, 85, 60, 30, 40, 50, 50};

        requests_sent     = 0;
        cap_writes        = 0;
        send_quiet        = 1'b0;
        recv_quiet        = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_PUSH;
        req_ch.push_value = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cap = (phase_cap[p] < 0) ? $urandom_range(1, 256) : phase_cap[p];
            set_capacity(cap);
            // Some phases run a side at full rate, some both, the rest with gaps.
            send_quiet = (p == 1) || (p == 5);
            recv_quiet = (p == 1) || (p == 6);
            for (int n = 0; n < phase_len[p]; n++)
                send_request(pick_cmd(phase_bias[p], phase_bias[p] < 80), pick_word());
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests under %0d capacity settings; %0d results checked.",
                 requests_sent, cap_writes, results_checked);
        $display("Deepest fill reached: %0d entries.", peak_fill);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
sv/bse_pkg.sv
sv/bse_req_if.sv
sv/bse_rsp_if.sv
sv/bse_ram.sv
sv/bse_ctrl.sv
sv/bounded_stack_engine.sv
dv/bse_stack_checker.sv
dv/bounded_stack_engine_tb.sv
